// ===== rtl/core/rgpt_pkg.sv =====
`timescale 1ns / 1ps

package rgpt_pkg;

  // Default number of CPUs tracked
  localparam int unsigned DefMaxCpus = 64;

  // Field widths
  localparam int unsigned CpuW   = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned GenW   = 64;

  // Reset value of the CPU count register
  localparam logic [CountW-1:0] CpuCountRst = CountW'(64);

  // One quiescent report
  typedef struct packed {
    logic [CpuW-1:0] cpu_index;
    logic            next_nonempty;
  } req_t;

  // One result
  typedef struct packed {
    logic            release_batch;
    logic            batch_queued;
    logic [GenW-1:0] global_gen_out;
    logic [GenW-1:0] cpu_target_gen_out;
    logic            period_active;
  } rsp_t;

  // Write port of the target generation store
  typedef struct packed {
    logic            en;
    logic [CpuW-1:0] addr;
    logic [GenW-1:0] data;
  } tgt_wr_t;

endpackage

// ===== rtl/core/rgpt_req_if.sv =====
`timescale 1ns / 1ps

interface rgpt_req_if
  import rgpt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CpuW-1:0] cpu_index;
  logic            next_nonempty;

  modport source (output valid, output cpu_index, output next_nonempty, input ready);
  modport sink   (input valid, input cpu_index, input next_nonempty, output ready);
endinterface

// ===== rtl/core/rgpt_rsp_if.sv =====
`timescale 1ns / 1ps

interface rgpt_rsp_if
  import rgpt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            release_batch;
  logic            batch_queued;
  logic [GenW-1:0] global_gen_out;
  logic [GenW-1:0] cpu_target_gen_out;
  logic            period_active;

  modport source (output valid, output release_batch, output batch_queued,
                  output global_gen_out, output cpu_target_gen_out,
                  output period_active, input ready);
  modport sink   (input valid, input release_batch, input batch_queued,
                  input global_gen_out, input cpu_target_gen_out,
                  input period_active, output ready);
endinterface

// ===== rtl/core/rgpt_target_ram.sv =====
`timescale 1ns / 1ps

module rgpt_target_ram
  import rgpt_pkg::*;
#(
  parameter int unsigned DEPTH = DefMaxCpus
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [CpuW-1:0] rd_addr,
  input  tgt_wr_t         wr,
  output logic [GenW-1:0] rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [GenW-1:0] mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  // Registered read, write-first on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr[AW-1:0]];
      end
    end
  end

endmodule

// ===== rtl/core/rgpt_core.sv =====
`timescale 1ns / 1ps

module rgpt_core
  import rgpt_pkg::*;
#(
  parameter int unsigned MAX_CPUS = DefMaxCpus
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CountW-1:0] cpu_count,
  input  req_t              cur_req,
  input  logic [GenW-1:0]   rd_data,
  output rsp_t              result,
  output tgt_wr_t           tgt_wr
);

  // Only the first 64 CPUs can ever be addressed by a report
  localparam int unsigned Depth = (MAX_CPUS < (2 ** CpuW)) ? MAX_CPUS : (2 ** CpuW);
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  // Owed count covers CPUs beyond the addressable range as well
  localparam int unsigned NMax  = (MAX_CPUS < ((2 ** CountW) - 1)) ? MAX_CPUS
                                                                   : ((2 ** CountW) - 1);
  localparam int unsigned CW    = $clog2(NMax + 1);

  logic [Depth-1:0] owed;
  logic [Depth-1:0] pend;
  logic [Depth-1:0] tvalid;
  logic [CW-1:0]    owed_cnt;
  logic [GenW-1:0]  gen;
  logic [GenW-1:0]  hi;

  logic             in_range;
  logic [AW-1:0]    idx;
  int unsigned      n_load;
  logic [CW-1:0]    load_cnt;
  logic [Depth-1:0] load_mask;
  logic             owed_c;
  logic             last;
  logic             start1;
  logic             start3;
  logic [GenW-1:0]  gp1, gp2, gp3, gp4;
  logic [GenW-1:0]  g2;
  logic [GenW-1:0]  tgt_new;
  logic [GenW-1:0]  hi_q;
  logic [GenW-1:0]  tgt_rd;
  logic [CW-1:0]    cnt1;
  logic [CW-1:0]    cnt_next;
  logic [GenW-1:0]  gen_next;
  logic [GenW-1:0]  hi_next;
  logic             rel;
  logic             pend_after;
  logic             queue;
  logic             upd;

  // Mask loaded at period start
  always_comb begin
    n_load   = (32'(cpu_count) > MAX_CPUS) ? MAX_CPUS : 32'(cpu_count);
    load_cnt = CW'(n_load);
    for (int i = 0; i < Depth; i++) begin
      load_mask[i] = (i < n_load);
    end
  end

  // Generation candidates, all off the current register
  assign gp1 = gen + GenW'(1);
  assign gp2 = gen + GenW'(2);
  assign gp3 = gen + GenW'(3);
  assign gp4 = gen + GenW'(4);

  // Step evaluation
  always_comb begin
    in_range = (32'(cur_req.cpu_index) < MAX_CPUS);
    idx      = cur_req.cpu_index[AW-1:0];
    owed_c   = owed[idx];
    last     = owed_c && (owed_cnt == CW'(1));
    // last report with gen+1 <= hi starts a new period
    start1   = last && (gp1 <= hi);

    if (start1) begin
      g2      = gp2;
      tgt_new = gp3;
      hi_q    = gp4;
    end else if (last) begin
      g2      = gp1;
      tgt_new = gp2;
      hi_q    = gp3;
    end else begin
      g2      = gen;
      tgt_new = gp1;
      hi_q    = gp2;
    end

    cnt1       = start1 ? load_cnt : (owed_cnt - CW'(owed_c));
    tgt_rd     = tvalid[idx] ? rd_data : '0;
    rel        = pend[idx] && (g2 > tgt_rd);
    pend_after = pend[idx] && !rel;
    queue      = !pend_after && cur_req.next_nonempty;
    start3     = queue && (cnt1 == '0);

    gen_next = start3 ? tgt_new : g2;
    cnt_next = start3 ? load_cnt : cnt1;
    if (queue) begin
      hi_next = hi_q;
    end else if (start1) begin
      hi_next = gp3;
    end else begin
      hi_next = hi;
    end

    upd = step && in_range;
  end

  // Result of the step
  always_comb begin
    result.release_batch      = in_range && rel;
    result.batch_queued       = in_range && queue;
    result.global_gen_out     = in_range ? gen_next : gen;
    result.cpu_target_gen_out = in_range ? (queue ? tgt_new : tgt_rd) : '0;
    result.period_active      = in_range ? (cnt_next != '0) : (owed_cnt != '0);
  end

  // Target store write
  always_comb begin
    tgt_wr.en   = upd && queue;
    tgt_wr.addr = cur_req.cpu_index;
    tgt_wr.data = tgt_new;
  end

  // Tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      owed     <= '0;
      pend     <= '0;
      tvalid   <= '0;
      owed_cnt <= '0;
      gen      <= '0;
      hi       <= '0;
    end else if (upd) begin
      gen      <= gen_next;
      hi       <= hi_next;
      owed_cnt <= cnt_next;
      if (start1 || start3) begin
        owed <= load_mask;
      end else if (owed_c) begin
        owed[idx] <= 1'b0;
      end
      pend[idx] <= queue ? 1'b1 : pend_after;
      if (queue) begin
        tvalid[idx] <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rcu_grace_period_tracker_top.sv =====
`timescale 1ns / 1ps
// An accepted report is held in the input stage and its result in the result
// register on rsp. Throughput: one transaction per cycle unless rsp stalls; the
// target store read is issued on acceptance, the update when the report advances.
// Reset: mask, pending flags, generations cleared; cpu_count set to 64;
// target generations read as zero until written (per-entry valid flags).

module rcu_grace_period_tracker_top
  import rgpt_pkg::*;
#(
  parameter int unsigned MAX_CPUS = DefMaxCpus
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_wdata,
  rgpt_req_if.sink          req,
  rgpt_rsp_if.source        rsp
);

  localparam int unsigned Depth = (MAX_CPUS < (2 ** CpuW)) ? MAX_CPUS : (2 ** CpuW);

  logic [CountW-1:0] cpu_count;
  logic              s_valid;
  req_t              s_req;
  logic              o_valid;
  rsp_t              o_rsp;
  logic              accept;
  logic              advance;
  logic [GenW-1:0]   rd_data;
  rsp_t              result;
  tgt_wr_t           tgt_wr;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_count <= CpuCountRst;
    end else if (cfg_we) begin
      cpu_count <= cfg_wdata;
    end
  end

  // Handshake
  assign advance   = s_valid && (!o_valid || rsp.ready);
  assign req.ready = !s_valid || advance;
  assign accept    = req.valid && req.ready;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_req.cpu_index     <= req.cpu_index;
      s_req.next_nonempty <= req.next_nonempty;
    end
  end

  rgpt_target_ram #(
    .DEPTH (Depth)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (req.cpu_index),
    .wr      (tgt_wr),
    .rd_data (rd_data)
  );

  rgpt_core #(
    .MAX_CPUS (MAX_CPUS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .cpu_count (cpu_count),
    .cur_req   (s_req),
    .rd_data   (rd_data),
    .result    (result),
    .tgt_wr    (tgt_wr)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_rsp <= result;
    end
  end

  assign rsp.valid              = o_valid;
  assign rsp.release_batch      = o_rsp.release_batch;
  assign rsp.batch_queued       = o_rsp.batch_queued;
  assign rsp.global_gen_out     = o_rsp.global_gen_out;
  assign rsp.cpu_target_gen_out = o_rsp.cpu_target_gen_out;
  assign rsp.period_active      = o_rsp.period_active;

endmodule
